// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== hw/rtl/rrts_pkg.sv =====
// Types and constants of the round-robin thread scheduler.
// Used by the sleep counter cells, the ring head and the top level.
package rrts_pkg;

    localparam int MAX_THREADS   = 16;
    localparam int SLOT_W        = $clog2(MAX_THREADS);
    localparam int COUNT_W       = $clog2(MAX_THREADS + 1);
    localparam int OUT_SLOT_W    = 4;
    localparam int SLEEP_W       = 32;
    localparam int MS_W          = 24;
    localparam int FRAC_W        = 8;
    localparam int QUANTUM_W     = 16;
    localparam int TICK_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(10);
    localparam logic [TICK_W-1:0]    TICK_RESET    = TICK_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICK    = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_YIELD = 2'd1,
        OP_SLEEP = 2'd2,
        OP_ADD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op             op;
        logic [MS_W-1:0] sleep_ms;
    } t_in_word;

    typedef struct packed {
        logic [OUT_SLOT_W-1:0] running_slot;
        logic                  switched;
        logic                  running_asleep;
        logic [OUT_SLOT_W-1:0] added_slot;
        logic                  table_full;
    } t_out_word;

    // Control handed to the ring head for one walk over the slots.
    typedef struct packed {
        t_op                op;
        logic [SLOT_W-1:0]  step;
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  run;
        logic               add_en;
        logic [SLOT_W-1:0]  add_slot;
        logic [TICK_W-1:0]  tick_len;
        logic [SLEEP_W-1:0] sleep_val;
    } t_walk_ctl;

endpackage

// ===== hw/rtl/rrts_cell.sv =====
// One sleep counter cell of the slot ring.
// Depends on rrts_pkg for the counter width.
module rrts_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic [rrts_pkg::SLEEP_W-1:0] i_d,
    output logic [rrts_pkg::SLEEP_W-1:0] o_q
);
    import rrts_pkg::*;

    logic [SLEEP_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hw/rtl/rrts_head.sv =====
// Update stage at the entry of the slot ring: applies the event to the
// counter of the slot passing by. Depends on rrts_pkg.
module rrts_head (
    input  rrts_pkg::t_walk_ctl          i_ctl,
    input  logic [rrts_pkg::SLEEP_W-1:0] i_q,
    output logic [rrts_pkg::SLEEP_W-1:0] o_d
);
    import rrts_pkg::*;

    logic [SLEEP_W-1:0] w_tick;

    assign w_tick = SLEEP_W'(i_ctl.tick_len);

    always_comb begin
        o_d = i_q;
        case (i_ctl.op)
            OP_TICK: begin
                // only occupied slots count down, saturating at zero
                if (COUNT_W'(i_ctl.step) < i_ctl.count) begin
                    o_d = (i_q > w_tick) ? (i_q - w_tick) : '0;
                end
            end
            OP_SLEEP: begin
                if (i_ctl.step == i_ctl.run) begin
                    o_d = i_ctl.sleep_val;
                end
            end
            OP_ADD: begin
                if (i_ctl.add_en && (i_ctl.step == i_ctl.add_slot)) begin
                    o_d = '0;
                end
            end
            default: begin
                o_d = i_q;
            end
        endcase
    end

endmodule

// ===== hw/rtl/round_robin_thread_scheduler_unit.sv =====
// Round-robin thread scheduler: top level with event control and the slot ring.
// Depends on rrts_pkg, rrts_cell, rrts_head and assert_macros.svh.
//
// Each event word walks one full turn of the ring between acceptance and the
// moment its result enters the output register. The sleep counters sit in a
// ring of cells that rotates once per cycle past a single update stage, so
// one full turn of the ring sets the time per event, plus the load of the result
// in state ST_DONE. Input is ready again only in ST_IDLE after that load, so a
// new event is not accepted before the previous result is loaded. Scalar state
// (quantum, running slot, thread count) settles at acceptance. A new event is
// taken while the previous result still waits at the output; a result that
// still waits when the next one is done holds that one, and the input with it.
`include "assert_macros.svh"

module round_robin_thread_scheduler_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  rrts_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output rrts_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rrts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rrts_pkg::*;

    t_state             r_state, n_state;
    logic [QUANTUM_W-1:0] r_quantum_ticks;
    logic [TICK_W-1:0]  r_tick_len;
    logic [QUANTUM_W-1:0] r_q, n_q;
    logic [SLOT_W-1:0]  r_run, n_run;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [SLOT_W-1:0]  r_step;
    t_op                r_op;
    logic [SLEEP_W-1:0] r_sleep_val;
    logic               r_switched, n_switched;
    logic               r_add_en, n_add_en;
    logic [SLOT_W-1:0]  r_add_slot, n_add_slot;
    logic               r_full, n_full;
    logic               r_asleep;
    logic               r_out_valid;
    t_out_word          r_out;

    logic               w_in_acc;
    logic               w_cfg_acc;
    logic               w_walk;
    logic               w_last_step;
    logic               w_load_out;
    logic [COUNT_W-1:0] w_run_inc;
    logic [SLEEP_W-1:0] w_ring [MAX_THREADS];
    logic [SLEEP_W-1:0] w_head_d;
    t_walk_ctl          w_ctl;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_last_step = (r_step == SLOT_W'(MAX_THREADS - 1));

    // ---- state machine ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_last_step) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        w_walk     = (r_state == ST_WALK);
        w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    end

    // ---- scalar update at acceptance ----
    assign w_run_inc = COUNT_W'(r_run) + COUNT_W'(1);

    always_comb begin
        n_q        = r_q;
        n_run      = r_run;
        n_count    = r_count;
        n_switched = 1'b0;
        n_add_en   = 1'b0;
        n_add_slot = '0;
        n_full     = 1'b0;
        case (i_in_word.op)
            OP_TICK: begin
                if (r_q <= QUANTUM_W'(1)) begin
                    // quantum ran out: advance and reload
                    n_run      = (w_run_inc == r_count) ? '0 : SLOT_W'(w_run_inc);
                    n_switched = 1'b1;
                    n_q        = r_quantum_ticks;
                end else begin
                    n_q = r_q - QUANTUM_W'(1);
                end
            end
            OP_YIELD: begin
                n_q = '0;
            end
            OP_SLEEP: begin
                if (i_in_word.sleep_ms != '0) begin
                    n_q = '0;
                end
            end
            OP_ADD: begin
                if (r_count < COUNT_W'(MAX_THREADS)) begin
                    n_add_en   = 1'b1;
                    n_add_slot = SLOT_W'(r_count);
                    n_count    = r_count + COUNT_W'(1);
                end else begin
                    n_full = 1'b1;
                end
            end
            default: begin
                n_q = r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_quantum_ticks <= QUANTUM_RESET;
            r_tick_len      <= TICK_RESET;
            r_q             <= QUANTUM_RESET;
            r_run           <= '0;
            r_count         <= COUNT_W'(1);
            r_step          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                case (i_cfg_index)
                    CFG_QUANTUM: r_quantum_ticks <= QUANTUM_W'(i_cfg_data);
                    CFG_TICK:    r_tick_len      <= TICK_W'(i_cfg_data);
                    default:     ;
                endcase
            end
            if (w_in_acc) begin
                r_q     <= n_q;
                r_run   <= n_run;
                r_count <= n_count;
            end
            if (w_walk) begin
                r_step <= r_step + SLOT_W'(1);
            end else begin
                r_step <= '0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- event payload and result ----
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op        <= i_in_word.op;
            r_sleep_val <= {i_in_word.sleep_ms, {FRAC_W{1'b0}}};
            r_switched  <= n_switched;
            r_add_en    <= n_add_en;
            r_add_slot  <= n_add_slot;
            r_full      <= n_full;
        end
        // catch the running slot's counter as it passes the head
        if (w_walk && (r_step == r_run)) begin
            r_asleep <= (w_head_d != '0);
        end
        if (w_load_out) begin
            r_out.running_slot   <= OUT_SLOT_W'(r_run);
            r_out.switched       <= r_switched;
            r_out.running_asleep <= r_asleep;
            r_out.added_slot     <= r_add_en ? OUT_SLOT_W'(r_add_slot) : '0;
            r_out.table_full     <= r_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ---- slot ring: cell 0 holds slot r_step, the head refills the tail ----
    always_comb begin
        w_ctl.op        = r_op;
        w_ctl.step      = r_step;
        w_ctl.count     = r_count;
        w_ctl.run       = r_run;
        w_ctl.add_en    = r_add_en;
        w_ctl.add_slot  = r_add_slot;
        w_ctl.tick_len  = r_tick_len;
        w_ctl.sleep_val = r_sleep_val;
    end

    rrts_head u_head (
        .i_ctl (w_ctl),
        .i_q   (w_ring[0]),
        .o_d   (w_head_d)
    );

    for (genvar g = 0; g < MAX_THREADS; g++) begin : g_cell
        if (g == MAX_THREADS - 1) begin : g_tail
            rrts_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_walk),
                .i_d     (w_head_d),
                .o_q     (w_ring[g])
            );
        end else begin : g_body
            rrts_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_walk),
                .i_d     (w_ring[g+1]),
                .o_q     (w_ring[g])
            );
        end
    end

    // ---- assertions ----
    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1,
        (r_count != '0) && (r_count <= COUNT_W'(MAX_THREADS)))
    `ASSERT_IMPL(a_run_below_count, i_clk, i_rst_n, 1'b1, COUNT_W'(r_run) < r_count)
    `ASSERT_NEXT(a_walk_starts, i_clk, i_rst_n, w_in_acc,
        (r_state == ST_WALK) && (r_step == '0))
    `ASSERT_IMPL(a_full_no_slot, i_clk, i_rst_n, o_out_valid && o_out_word.table_full,
        o_out_word.added_slot == '0)

endmodule

// ===== sim/tb_top.sv =====
// Testbench for round_robin_thread_scheduler_unit: random and directed event words
// checked against an in-bench model of the scheduler state held in a scoreboard class.
// Depends on rrts_pkg and the scheduler RTL.
module tb_top;
    import rrts_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PIPE_DRAIN     = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    class sched_scoreboard;
        logic [SLEEP_W-1:0]   sleep_left [MAX_THREADS];
        logic [COUNT_W-1:0]   thread_count;
        logic [SLOT_W-1:0]    running;
        logic [QUANTUM_W-1:0] quantum_left;
        logic [QUANTUM_W-1:0] quantum_ticks;
        logic [TICK_W-1:0]    tick_len;
        t_out_word            words_due[$];
        int                   errors;
        int                   results_seen;

        function new();
            foreach (sleep_left[i]) sleep_left[i] = '0;
            thread_count  = COUNT_W'(1);
            running       = '0;
            quantum_left  = QUANTUM_RESET;
            quantum_ticks = QUANTUM_RESET;
            tick_len      = TICK_RESET;
            errors        = 0;
            results_seen  = 0;
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        // Indexes other than the two registers are dropped by the block.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_QUANTUM)
                quantum_ticks = data;
            else if (idx == CFG_TICK)
                tick_len = data;
        endfunction

        function void note_event(t_in_word w);
            t_out_word r;
            r = '0;
            case (w.op)
                OP_TICK: begin
                    for (int i = 0; i < int'(thread_count); i++)
                        sleep_left[i] = (sleep_left[i] > tick_len) ?
                                        sleep_left[i] - tick_len : '0;
                    if (quantum_left <= 1) begin
                        running      = SLOT_W'((int'(running) + 1) % int'(thread_count));
                        r.switched   = 1'b1;
                        quantum_left = quantum_ticks;
                    end else begin
                        quantum_left = quantum_left - 1'b1;
                    end
                end
                OP_YIELD: quantum_left = '0;
                OP_SLEEP: begin
                    sleep_left[running] = {w.sleep_ms, {FRAC_W{1'b0}}};
                    if (w.sleep_ms != 0)
                        quantum_left = '0;
                end
                OP_ADD: begin
                    if (thread_count < MAX_THREADS) begin
                        r.added_slot = OUT_SLOT_W'(thread_count);
                        sleep_left[thread_count[SLOT_W-1:0]] = '0;
                        thread_count = thread_count + 1'b1;
                    end else begin
                        r.table_full = 1'b1;
                    end
                end
                default: ;
            endcase
            r.running_slot   = OUT_SLOT_W'(running);
            r.running_asleep = (sleep_left[running] != 0);
            words_due.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("word %0d field %s got %0h want %0h",
                                 results_seen, name, got, want));
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            results_seen++;
            if (words_due.size() == 0) begin
                report($sformatf("word %0d arrived with no event pending", results_seen));
                return;
            end
            want = words_due.pop_front();
            check_field("running_slot", got.running_slot, want.running_slot);
            check_field("switched", got.switched, want.switched);
            check_field("running_asleep", got.running_asleep, want.running_asleep);
            check_field("added_slot", got.added_slot, want.added_slot);
            check_field("table_full", got.table_full, want.table_full);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_word              in_word = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic                  o_cfg_ready;

    bit                    in_gaps_on = 1'b1;
    bit                    out_stalls_on = 1'b1;
    int                    quiet_cycles = 0;
    sched_scoreboard       sb;

    round_robin_thread_scheduler_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Receiver: stall in bursts, otherwise take every word.
    initial begin
        forever begin
            if (out_stalls_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready)
            sb.check_result(o_out_word);
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_in_word make_event(t_op op, logic [MS_W-1:0] ms);
        t_in_word w;
        w.op       = op;
        w.sleep_ms = ms;
        return w;
    endfunction

    // Mostly short sleeps so counters run out within a few ticks.
    function automatic logic [MS_W-1:0] rand_sleep();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 5)
            return '0;
        else if (r < 15)
            return MS_W'($urandom_range(1, 16));
        else if (r < 18)
            return MS_W'($urandom_range(17, 4000));
        else if (r == 18)
            return MS_W'($urandom());
        return '1;
    endfunction

    function automatic t_in_word rand_event();
        t_in_word    w;
        int unsigned r;
        r          = $urandom_range(0, 99);
        w.sleep_ms = MS_W'($urandom());
        if (r < 55) begin
            w.op = OP_TICK;
        end else if (r < 66) begin
            w.op = OP_YIELD;
        end else if (r < 94) begin
            w.op       = OP_SLEEP;
            w.sleep_ms = rand_sleep();
        end else begin
            w.op = OP_ADD;
        end
        return w;
    endfunction

    task automatic send_event(t_in_word w);
        if (in_gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!o_in_ready);
        sb.note_event(w);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Drop valid and let the ring finish its turn before touching registers.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic run_phase(logic [QUANTUM_W-1:0] quantum, logic [TICK_W-1:0] tick,
                             int n, bit gaps);
        settle();
        write_reg(CFG_QUANTUM, quantum);
        write_reg(CFG_TICK, tick);
        in_gaps_on    = gaps;
        out_stalls_on = gaps;
        repeat (n) send_event(rand_event());
    endtask

    task automatic directed_events();
        send_event(make_event(OP_TICK, '0));
        send_event(make_event(OP_SLEEP, '1));
        send_event(make_event(OP_TICK, 24'hAAAAAA));   // single thread wraps to itself
        send_event(make_event(OP_SLEEP, '0));
        send_event(make_event(OP_YIELD, 24'h555555));
        send_event(make_event(OP_TICK, '0));
        send_event(make_event(OP_ADD, '1));
        send_event(make_event(OP_ADD, '0));
        send_event(make_event(OP_SLEEP, MS_W'(1)));
        send_event(make_event(OP_TICK, '0));           // counter equal to tick saturates
        send_event(make_event(OP_YIELD, '0));
        send_event(make_event(OP_TICK, '1));
        send_event(make_event(OP_SLEEP, MS_W'(2)));
        send_event(make_event(OP_TICK, '0));
        send_event(make_event(OP_TICK, '0));
        send_event(make_event(OP_ADD, 24'h123456));
        send_event(make_event(OP_SLEEP, '1));
        send_event(make_event(OP_YIELD, '1));
        send_event(make_event(OP_TICK, '0));
        send_event(make_event(OP_TICK, '0));
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_events();

        run_phase(QUANTUM_W'(1), TICK_W'(1), 120, 1'b1);
        settle();
        write_reg(CFG_SPARE_2, '1);
        run_phase(QUANTUM_W'(0), '1, 120, 1'b1);      // zero quantum: every tick switches
        settle();
        write_reg(CFG_SPARE_3, '0);
        run_phase('1, TICK_W'(0), 100, 1'b0);
        run_phase(QUANTUM_W'($urandom_range(2, 12)), TICK_W'($urandom_range(1, 1024)),
                  200, 1'b1);
        run_phase(QUANTUM_W'(3), TICK_W'(256), 150, 1'b1);
        run_phase(QUANTUM_W'($urandom_range(1, 20)), TICK_W'($urandom_range(1, 65535)),
                  110, 1'b1);
        run_phase(QUANTUM_W'(5), TICK_W'(300), 150, 1'b0);

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== round_robin_thread_scheduler_unit.f =====
+incdir+hw/rtl
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_cell.sv
hw/rtl/rrts_head.sv
hw/rtl/round_robin_thread_scheduler_unit.sv
sim/tb_top.sv
